// File: rtl/til_pkg.sv
// shared types and constants for the table interpolation lookup block
// used by til_ctrl, til_dp and table_interpolation_lookup; depends on nothing
package til_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  // configuration port
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_TABLE_SIZE  = 2'd0;
  localparam reg_idx_t REG_ALLOW_EXTRAP = 2'd1;
  localparam reg_idx_t REG_SEARCH_ON_X = 2'd2;

  // item kinds carried on tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD,
    OP_RD_MID,
    OP_CMP,
    OP_RD_CLAMP,
    OP_CLAMP_RES,
    OP_RD_B0,
    OP_RD_B1,
    OP_DIFF,
    OP_ZERO_RES,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_one;      // single-entry table
    logic srch_done;  // binary search window empty
    logic clamp;      // result is an end entry
    logic dk_zero;    // key delta is zero
    logic mul_done;   // last partial product step
    logic div_last;   // last quotient bit
    logic out_busy;   // result register still occupied
  } dp_stat_t;

endpackage

// File: rtl/til_ctrl.sv
// controller state machine for the table interpolation lookup block
// sequences search, multiply and divide in til_dp; depends on til_pkg
module til_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  input  logic              out_tready,
  input  til_pkg::dp_stat_t stat,
  output til_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RDM,
    S_CMP,
    S_RDC,
    S_CLV,
    S_RD0,
    S_RD1,
    S_DIFF,
    S_ZCHK,
    S_MUL,
    S_DIVI,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = til_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == til_pkg::CMD_LOOKUP) begin
            cmd.op    = til_pkg::OP_LOAD;
            state_nxt = S_CHK;
          end else begin
            cmd.op = til_pkg::OP_WRITE;
          end
        end
      end
      S_CHK: begin
        state_nxt = stat.n_one ? S_RDC : S_RDM;
      end
      S_RDM: begin
        if (stat.srch_done) begin
          state_nxt = stat.clamp ? S_RDC : S_RD0;
        end else begin
          cmd.op    = til_pkg::OP_RD_MID;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.op    = til_pkg::OP_CMP;
        state_nxt = S_RDM;
      end
      S_RDC: begin
        cmd.op    = til_pkg::OP_RD_CLAMP;
        state_nxt = S_CLV;
      end
      S_CLV: begin
        cmd.op    = til_pkg::OP_CLAMP_RES;
        state_nxt = S_FIN;
      end
      S_RD0: begin
        cmd.op    = til_pkg::OP_RD_B0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.op    = til_pkg::OP_RD_B1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = til_pkg::OP_DIFF;
        state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        if (stat.dk_zero) begin
          cmd.op    = til_pkg::OP_ZERO_RES;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = til_pkg::OP_MUL;
        if (stat.mul_done) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.op    = til_pkg::OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = til_pkg::OP_DIV;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy || out_tready) begin
          cmd.op    = til_pkg::OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/til_dp.sv
// datapath for the table interpolation lookup block: table memories, search
// window, serial multiply, bit-serial divide and result register; depends on til_pkg
module til_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  til_pkg::dp_cmd_t                   cmd,
  input  logic [til_pkg::IDX_W-1:0]          in_index,
  input  logic signed [til_pkg::DATA_W-1:0]  in_x,
  input  logic signed [til_pkg::DATA_W-1:0]  in_y,
  input  logic signed [til_pkg::DATA_W-1:0]  in_v,
  input  logic [til_pkg::CNT_W-1:0]          cfg_size,
  input  logic                               cfg_extrap,
  input  logic                               cfg_on_x,
  input  logic                               out_tready,
  output til_pkg::dp_stat_t                  stat,
  output logic                               out_tvalid,
  output logic [til_pkg::DATA_W-1:0]         out_tdata
);

  localparam int DW     = til_pkg::DATA_W;
  localparam int DIFF_W = DW + 1;              // key/value differences
  localparam int LO_W   = (DIFF_W + 1) / 2;    // low half of multiplier operand
  localparam int HI_W   = DIFF_W - LO_W;
  localparam int PP_W   = DIFF_W + LO_W;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int QBITS  = DW + 3;              // quotient bits kept before saturating
  localparam int TOP_W  = PROD_W - QBITS;
  localparam int QV_W   = QBITS + 1;
  localparam int SUM_W  = QV_W + 2;
  localparam int DCNT_W = $clog2(QBITS);
  localparam int CNT_W  = til_pkg::CNT_W;
  localparam int IDX_W  = til_pkg::IDX_W;

  // table memories, one read address shared by both columns
  logic [DW-1:0] mem_x [til_pkg::TABLE_DEPTH];
  logic [DW-1:0] mem_y [til_pkg::TABLE_DEPTH];
  logic [DW-1:0] rd_x_r, rd_y_r;
  logic [IDX_W-1:0] rd_addr;

  logic signed [DW-1:0] v_r, k0_r, v0_r;
  logic [CNT_W-1:0]     n_r, lo_r, hi_r;
  logic [IDX_W-1:0]     base_r;
  logic [DIFF_W-1:0]    dk_mag_r, dv_mag_r, ov_mag_r;
  logic                 neg_r, dk_zero_r;
  logic [1:0]           mul_cnt_r;
  logic [PP_W-1:0]      pp_r;
  logic [PROD_W-1:0]    prod_r;
  logic [DIFF_W-1:0]    rem_r;
  logic [QBITS-1:0]     quo_r, dvd_r;
  logic [DCNT_W-1:0]    div_cnt_r;
  logic                 ovf_r;
  logic                 out_valid_r;
  logic [DW-1:0]        out_data_r;

  logic signed [DW-1:0]     key, val;
  logic [CNT_W-1:0]         n_c, mid, base_c, clamp_c;
  logic [CNT_W:0]           mid_sum;
  logic signed [DIFF_W-1:0] dk, dv, ov;
  logic [DIFF_W:0]          r2;
  logic                     r_ge;
  logic [DIFF_W:0]          r_sub;
  logic [TOP_W-1:0]         prod_top;
  logic [QV_W-1:0]          qv;
  logic signed [SUM_W-1:0]  v0_ext, q_ext, sum;
  logic [DW-1:0]            sat_res;

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
    mag = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
  endfunction

  assign key = cfg_on_x ? rd_x_r : rd_y_r;
  assign val = cfg_on_x ? rd_y_r : rd_x_r;

  // entries in use, kept within one and the table depth
  always_comb begin
    priority if (cfg_size == '0) begin
      n_c = CNT_W'(1);
    end else if (cfg_size > CNT_W'(til_pkg::TABLE_DEPTH)) begin
      n_c = CNT_W'(til_pkg::TABLE_DEPTH);
    end else begin
      n_c = cfg_size;
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];

  // lower entry of the interpolation pair; end pairs when extrapolating
  always_comb begin
    priority if (lo_r == '0) begin
      base_c = '0;
    end else if (lo_r == n_r) begin
      base_c = n_r - CNT_W'(2);
    end else begin
      base_c = lo_r - CNT_W'(1);
    end
  end

  assign clamp_c = (lo_r == '0) ? '0 : (n_r - CNT_W'(1));

  always_comb begin
    unique case (cmd.op)
      til_pkg::OP_RD_CLAMP: rd_addr = clamp_c[IDX_W-1:0];
      til_pkg::OP_RD_B0:    rd_addr = base_c[IDX_W-1:0];
      til_pkg::OP_RD_B1:    rd_addr = base_r + IDX_W'(1);
      default:              rd_addr = mid[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == til_pkg::OP_WRITE) begin
      mem_x[in_index] <= in_x;
      mem_y[in_index] <= in_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign dk = {key[DW-1], key} - {k0_r[DW-1], k0_r};
  assign dv = {val[DW-1], val} - {v0_r[DW-1], v0_r};
  assign ov = {v_r[DW-1], v_r} - {k0_r[DW-1], k0_r};

  // restoring divide step
  assign r2       = {rem_r, dvd_r[QBITS-1]};
  assign r_ge     = r2 >= {1'b0, dk_mag_r};
  assign r_sub    = r2 - {1'b0, dk_mag_r};
  assign prod_top = prod_r[PROD_W-1:QBITS];

  // final add and saturation
  assign qv     = ovf_r ? {1'b1, {QBITS{1'b0}}} : {1'b0, quo_r};
  assign v0_ext = {{(SUM_W-DW){v0_r[DW-1]}}, v0_r};
  assign q_ext  = {2'b00, qv};
  assign sum    = neg_r ? (v0_ext - q_ext) : (v0_ext + q_ext);

  always_comb begin
    if (sum[SUM_W-1:DW-1] == '0 || sum[SUM_W-1:DW-1] == '1) begin
      sat_res = sum[DW-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      til_pkg::OP_LOAD: begin
        v_r  <= in_v;
        n_r  <= n_c;
        lo_r <= '0;
        hi_r <= n_c;
      end
      til_pkg::OP_CMP: begin
        if (v_r <= key) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + CNT_W'(1);
        end
      end
      til_pkg::OP_CLAMP_RES: begin
        v0_r  <= val;
        quo_r <= '0;
        ovf_r <= 1'b0;
        neg_r <= 1'b0;
      end
      til_pkg::OP_RD_B0: begin
        base_r <= base_c[IDX_W-1:0];
      end
      til_pkg::OP_RD_B1: begin
        k0_r <= key;
        v0_r <= val;
      end
      til_pkg::OP_DIFF: begin
        dk_mag_r  <= mag(dk);
        dv_mag_r  <= mag(dv);
        ov_mag_r  <= mag(ov);
        neg_r     <= (dv[DIFF_W-1] ^ ov[DIFF_W-1]) ^ dk[DIFF_W-1];
        dk_zero_r <= (dk == '0);
        mul_cnt_r <= '0;
      end
      til_pkg::OP_ZERO_RES: begin
        quo_r <= '0;
        ovf_r <= 1'b0;
      end
      til_pkg::OP_MUL: begin
        mul_cnt_r <= mul_cnt_r + 2'd1;
        unique case (mul_cnt_r)
          2'd0: begin
            pp_r <= dv_mag_r * ov_mag_r[LO_W-1:0];
          end
          2'd1: begin
            prod_r <= {{(PROD_W-PP_W){1'b0}}, pp_r};
            pp_r   <= dv_mag_r * {{(LO_W-HI_W){1'b0}}, ov_mag_r[DIFF_W-1:LO_W]};
          end
          default: begin
            prod_r <= prod_r + PROD_W'({pp_r, {LO_W{1'b0}}});
          end
        endcase
      end
      til_pkg::OP_DIV_INIT: begin
        ovf_r     <= {{(DIFF_W-TOP_W){1'b0}}, prod_top} >= dk_mag_r;
        rem_r     <= {{(DIFF_W-TOP_W){1'b0}}, prod_top};
        dvd_r     <= prod_r[QBITS-1:0];
        quo_r     <= '0;
        div_cnt_r <= DCNT_W'(QBITS - 1);
      end
      til_pkg::OP_DIV: begin
        rem_r     <= r_ge ? r_sub[DIFF_W-1:0] : r2[DIFF_W-1:0];
        quo_r     <= {quo_r[QBITS-2:0], r_ge};
        dvd_r     <= {dvd_r[QBITS-2:0], 1'b0};
        div_cnt_r <= div_cnt_r - DCNT_W'(1);
      end
      til_pkg::OP_FIN: begin
        out_data_r <= sat_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == til_pkg::OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.n_one     = (n_r == CNT_W'(1));
  assign stat.srch_done = (lo_r >= hi_r);
  assign stat.clamp     = !cfg_extrap && ((lo_r == '0) || (lo_r == n_r));
  assign stat.dk_zero   = dk_zero_r;
  assign stat.mul_done  = (mul_cnt_r == 2'd2);
  assign stat.div_last  = (div_cnt_r == '0);
  assign stat.out_busy  = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/table_interpolation_lookup.sv
// a write item is stored when it is taken; a lookup passes a check state, the binary search
// (a read and a compare state per memory probe, up to nine probes, plus a final read state,
// skipped for a single-entry table), then a read and clamp for an end entry, the pair fetch and
// zero result for equal keys, else the pair fetch, three multiply steps and the one-bit-per-cycle
// divider, and the result write; one item at a time, the next taken the cycle after the result
// write; a full result register that is not drained holds the lookup in its final state
module table_interpolation_lookup (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [103:0]                        in_tdata,   // entry_index, entry_x, entry_y, lookup_value
  input  logic                                in_tuser,   // cmd
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // interpolated
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [til_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [til_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [til_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  // reset: rst_n is synchronous active low; controller, output valid and configuration
  // registers return to reset values, the table contents are undefined until written

  localparam int DW    = til_pkg::DATA_W;
  localparam int IDX_W = til_pkg::IDX_W;
  localparam int CNT_W = til_pkg::CNT_W;

  // configuration registers
  logic [CNT_W-1:0]        table_size_r;
  logic                    allow_extrap_r;
  logic                    search_on_x_r;
  logic                    cfg_wr;
  til_pkg::reg_idx_t       cfg_idx;

  til_pkg::dp_cmd_t        dp_cmd;
  til_pkg::dp_stat_t       dp_stat;

  // unpack the input item, lowest field first
  logic [IDX_W-1:0]        in_index;
  logic signed [DW-1:0]    in_x, in_y, in_v;

  assign in_index = in_tdata[IDX_W-1:0];
  assign in_x     = in_tdata[IDX_W +: DW];
  assign in_y     = in_tdata[IDX_W+DW +: DW];
  assign in_v     = in_tdata[IDX_W+2*DW +: DW];

  // apb: no wait states, register index from the word address
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[til_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r   <= CNT_W'(1);
      allow_extrap_r <= 1'b0;
      search_on_x_r  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        til_pkg::REG_TABLE_SIZE:   table_size_r   <= cfg_pwdata[CNT_W-1:0];
        til_pkg::REG_ALLOW_EXTRAP: allow_extrap_r <= cfg_pwdata[0];
        til_pkg::REG_SEARCH_ON_X:  search_on_x_r  <= cfg_pwdata[0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      til_pkg::REG_TABLE_SIZE:
        cfg_prdata = {{(til_pkg::CFG_DATA_W-CNT_W){1'b0}}, table_size_r};
      til_pkg::REG_ALLOW_EXTRAP:
        cfg_prdata = {{(til_pkg::CFG_DATA_W-1){1'b0}}, allow_extrap_r};
      til_pkg::REG_SEARCH_ON_X:
        cfg_prdata = {{(til_pkg::CFG_DATA_W-1){1'b0}}, search_on_x_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // sequencer: search, fetch pair, multiply, divide, saturate
  til_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  // table memories and arithmetic
  til_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .in_index   (in_index),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_v       (in_v),
    .cfg_size   (table_size_r),
    .cfg_extrap (allow_extrap_r),
    .cfg_on_x   (search_on_x_r),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
